@@ rtl/core/sem_pkg.sv @@
`timescale 1ns / 1ps
// sem_pkg: constants, types and helper functions of the sobel edge magnitude core
// used by sem_if, sem_magnitude, sobel_edge_magnitude_core and sem_checker

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int PIX_W      = 8;
    localparam int IDX_W      = 2;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
    localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

    // q16 luma weights
    localparam logic [15:0] GRAY_WEIGHT_R = 16'd19595;
    localparam logic [15:0] GRAY_WEIGHT_G = 16'd38470;
    localparam logic [15:0] GRAY_WEIGHT_B = 16'd7471;

    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_GRAY_INPUT   = 2'd2;

    typedef logic [8:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic    start;
        logic    interior;
        window_t window;
    } mag_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] magnitude;
    } mag_rsp_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] vmax
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_MIN)
            r = SIZE_MIN;
        else if (v > vmax)
            r = vmax;
        return r;
    endfunction

    // raster step with wrap at row and frame end
    function automatic pos_t advance(
        input pos_t              p,
        input logic [SIZE_W-1:0] w,
        input logic [SIZE_W-1:0] h
    );
        pos_t r;
        r = p;
        if ((SIZE_W'(p.col) + SIZE_W'(1)) >= w)
        begin
            r.col = '0;
            if ((SIZE_W'(p.row) + SIZE_W'(1)) >= h)
                r.row = '0;
            else
                r.row = p.row + ROW_W'(1);
        end
        else
        begin
            r.col = p.col + COL_W'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/sem_if.sv @@
`timescale 1ns / 1ps
// sem_if: pixel input and edge result channel interfaces
// depends on sem_pkg

interface sem_pixel_if
    import sem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             flush;

    modport source (output valid, blue, green, red, flush, input ready);
    modport sink (input valid, blue, green, red, flush, output ready);
endinterface

interface sem_result_if
    import sem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic             frame_end;

    modport source (output valid, edge_value, out_row, out_column, frame_end, input ready);
    modport sink (input valid, edge_value, out_row, out_column, frame_end, output ready);
endinterface

@@ rtl/core/sobel_edge_magnitude_core.sv @@
`timescale 1ns / 1ps
// sobel_edge_magnitude_core: 3x3 sobel gradient magnitude over a raster pixel stream
// depends on sem_pkg, sem_if and sem_magnitude
//
//  channel  role    handshake        payload
//  pixel    sink    valid / ready    blue, green, red, flush
//  result   source  valid / ready    edge_value, out_row, out_column, frame_end
//  cfg      write   cfg_write        cfg_index, cfg_data
//
// one item at a time: no new pixel is taken until the last pixel, and any result it yields,
// has reached the result register; interior outputs use the 8-step square root in sem_magnitude
// line stores are read at accept and written back in the update cycle
// the result register lets the next pixel be taken while a result waits
// rst_n clears control, counters and window; line stores hold no reset

module sobel_edge_magnitude_core
    import sem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sem_pixel_if.sink          pixel,
    sem_result_if.source       result,
    input  logic               cfg_write,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [SIZE_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_UPDATE = 5'b00100,
        S_WAIT   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic              gray_mode_reg;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] older_rd_reg, newer_rd_reg;

    logic [PIX_W-1:0] blue_reg, green_reg, red_reg;
    logic [23:0]      prod_r_reg, prod_g_reg, prod_b_reg;

    window_t     window_reg, window_next;
    pos_t        in_pos_reg, in_pos_next;
    pos_t        out_pos_reg, out_pos_next;
    logic [SIZE_W-1:0] pending_reg, pending_next;
    logic        start_reg, start_next;

    pos_t        emit_pos_reg;
    logic        emit_last_reg, emit_interior_reg;
    logic [PIX_W-1:0] mag_reg;

    logic        out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_value_reg;
    pos_t        out_loc_reg;
    logic        out_last_reg;

    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [SIZE_W:0]   w_plus1;
    logic [23:0]       gray_sum;
    logic [PIX_W-1:0]  gray;
    logic              accept, emit_now, out_load;
    logic              out_interior, out_last;

    mag_req_t mag_req;
    mag_rsp_t mag_rsp;

    sem_magnitude u_magnitude (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mag_req),
        .rsp   (mag_rsp)
    );

    assign w_eff    = clamp_size(width_reg, WIDTH_MAX);
    assign h_eff    = clamp_size(height_reg, HEIGHT_MAX);
    assign w_plus1  = {1'b0, w_eff} + (SIZE_W+1)'(1);
    assign gray_sum = prod_r_reg + prod_g_reg + prod_b_reg;
    assign gray     = gray_mode_reg ? blue_reg : gray_sum[23:16];

    assign pixel.ready = (state_reg == S_IDLE);
    assign accept      = pixel.valid && pixel.ready;
    assign out_load    = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    assign out_interior = (out_pos_reg.row != '0)
                       && ((SIZE_W'(out_pos_reg.row) + SIZE_W'(1)) < h_eff)
                       && (out_pos_reg.col != '0)
                       && ((SIZE_W'(out_pos_reg.col) + SIZE_W'(1)) < w_eff);
    assign out_last     = ((SIZE_W'(out_pos_reg.row) + SIZE_W'(1)) >= h_eff)
                       && ((SIZE_W'(out_pos_reg.col) + SIZE_W'(1)) >= w_eff);

    assign mag_req.start    = start_reg;
    assign mag_req.interior = emit_interior_reg;
    assign mag_req.window   = window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            gray_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg     <= cfg_data;
                REG_FRAME_HEIGHT: height_reg    <= cfg_data;
                REG_GRAY_INPUT:   gray_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_rd_reg <= older_mem[in_pos_reg.col];
            newer_rd_reg <= newer_mem[in_pos_reg.col];
        end
        if (state_reg == S_UPDATE)
        begin
            older_mem[in_pos_reg.col] <= newer_rd_reg;
            newer_mem[in_pos_reg.col] <= gray;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blue_reg  <= pixel.blue;
            green_reg <= pixel.green;
            red_reg   <= pixel.red;
        end
        if (state_reg == S_MUL)
        begin
            prod_r_reg <= GRAY_WEIGHT_R * red_reg;
            prod_g_reg <= GRAY_WEIGHT_G * green_reg;
            prod_b_reg <= GRAY_WEIGHT_B * blue_reg;
        end
        if (emit_now)
        begin
            emit_pos_reg      <= out_pos_reg;
            emit_last_reg     <= out_last;
            emit_interior_reg <= out_interior;
        end
        if (state_reg == S_WAIT && mag_rsp.done)
            mag_reg <= mag_rsp.magnitude;
        if (out_load)
        begin
            out_value_reg <= mag_reg;
            out_loc_reg   <= emit_pos_reg;
            out_last_reg  <= emit_last_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        window_next  = window_reg;
        in_pos_next  = in_pos_reg;
        out_pos_next = out_pos_reg;
        pending_next = pending_reg;
        start_next   = 1'b0;
        emit_now     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!pixel.flush)
                    begin
                        state_next = S_MUL;
                    end
                    else if (in_pos_reg.row == '0 && in_pos_reg.col == '0
                             && pending_reg != '0)
                    begin
                        pending_next = pending_reg - SIZE_W'(1);
                        emit_now     = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    window_next[i*3]   = window_reg[i*3+1];
                    window_next[i*3+1] = window_reg[i*3+2];
                end
                window_next[2] = older_rd_reg;
                window_next[5] = newer_rd_reg;
                window_next[8] = gray;
                in_pos_next    = advance(in_pos_reg, w_eff, h_eff);
                state_next     = S_IDLE;
                if ({1'b0, pending_reg} >= w_plus1)
                begin
                    pending_next = w_plus1[SIZE_W-1:0];
                    emit_now     = 1'b1;
                end
                else
                begin
                    pending_next = pending_reg + SIZE_W'(1);
                end
            end
            S_WAIT:
            begin
                if (mag_rsp.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit_now)
        begin
            out_pos_next = advance(out_pos_reg, w_eff, h_eff);
            start_next   = 1'b1;
            state_next   = S_WAIT;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= '0;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            pending_reg   <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            in_pos_reg    <= in_pos_next;
            out_pos_reg   <= out_pos_next;
            pending_reg   <= pending_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.edge_value = out_value_reg;
    assign result.out_row    = out_loc_reg.row;
    assign result.out_column = out_loc_reg.col;
    assign result.frame_end  = out_last_reg;

endmodule

@@ rtl/core/sem_magnitude.sv @@
`timescale 1ns / 1ps
// sem_magnitude: sobel gradients, sum of squares and iterative clamped square root
// depends on sem_pkg

module sem_magnitude
    import sem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mag_req_t req,
    output mag_rsp_t rsp
);

    typedef enum logic [2:0] {
        M_IDLE   = 3'b001,
        M_SQUARE = 3'b010,
        M_ROOT   = 3'b100
    } mag_state_t;

    mag_state_t state_reg, state_next;
    logic [9:0]       abs_gx_reg, abs_gy_reg;
    logic             interior_reg;
    logic [20:0]      sq_reg;
    logic [PIX_W-1:0] root_reg, root_next;
    logic [2:0]       step_reg, step_next;

    logic [9:0]       right_sum, left_sum, bottom_sum, top_sum;
    logic [10:0]      gx, gy;
    logic [PIX_W-1:0] trial;
    logic [15:0]      trial_sq;
    logic             big, finish;
    logic [PIX_W-1:0] root_new;

    always_comb
    begin
        right_sum  = 10'(req.window[2]) + {1'b0, req.window[5], 1'b0} + 10'(req.window[8]);
        left_sum   = 10'(req.window[0]) + {1'b0, req.window[3], 1'b0} + 10'(req.window[6]);
        bottom_sum = 10'(req.window[6]) + {1'b0, req.window[7], 1'b0} + 10'(req.window[8]);
        top_sum    = 10'(req.window[0]) + {1'b0, req.window[1], 1'b0} + 10'(req.window[2]);
        gx = {1'b0, right_sum} - {1'b0, left_sum};
        gy = {1'b0, bottom_sum} - {1'b0, top_sum};
    end

    always_comb
    begin
        trial    = root_reg | (8'h80 >> step_reg);
        trial_sq = trial * trial;
        root_new = (trial_sq <= sq_reg[15:0]) ? trial : root_reg;
        big      = (sq_reg[20:16] != '0);
        finish   = !interior_reg || big || (step_reg == 3'd7);
    end

    always_comb
    begin
        state_next = state_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                    state_next = M_SQUARE;
            end
            M_SQUARE:
            begin
                root_next  = '0;
                step_next  = '0;
                state_next = M_ROOT;
            end
            M_ROOT:
            begin
                root_next = root_new;
                step_next = step_reg + 3'd1;
                if (finish)
                    state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            root_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            root_reg  <= root_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && req.start)
        begin
            abs_gx_reg   <= gx[10] ? 10'(-gx) : gx[9:0];
            abs_gy_reg   <= gy[10] ? 10'(-gy) : gy[9:0];
            interior_reg <= req.interior;
        end
        if (state_reg == M_SQUARE)
            sq_reg <= 21'(abs_gx_reg * abs_gx_reg) + 21'(abs_gy_reg * abs_gy_reg);
    end

    always_comb
    begin
        rsp.done = (state_reg == M_ROOT) && finish;
        if (!interior_reg)
            rsp.magnitude = '0;
        else if (big)
            rsp.magnitude = MAG_MAX;
        else
            rsp.magnitude = root_new;
    end

endmodule

@@ rtl/core/sem_checker.sv @@
`timescale 1ns / 1ps
// sem_checker: port level assertions for sobel_edge_magnitude_core
// depends on sem_pkg; bound to the top level below

module sem_checker
    import sem_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_ready,
    input logic             pixel_flush,
    input logic             result_valid,
    input logic             result_ready,
    input logic [PIX_W-1:0] edge_value,
    input logic [ROW_W-1:0] out_row,
    input logic [COL_W-1:0] out_column,
    input logic             frame_end
);

    // a pixel transfer without flush makes the core busy and drops pixel ready
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && !pixel_flush |=> !pixel_ready)
        else $error("ready high right after a pixel transfer");

    // first row and first column are border outputs
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_row == '0 || out_column == '0) |-> edge_value == '0)
        else $error("nonzero edge value on first row or column");

    // the last pixel of a frame is a border corner
    a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_end |-> edge_value == '0 && out_row != '0 && out_column != '0)
        else $error("frame end output is not a zero corner");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(edge_value) && $stable(out_row)
            && $stable(out_column) && $stable(frame_end))
        else $error("result payload changed while stalled");

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .pixel_flush  (pixel.flush),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .edge_value   (result.edge_value),
    .out_row      (result.out_row),
    .out_column   (result.out_column),
    .frame_end    (result.frame_end)
);
